>>> rtl/lfrg_pkg.sv
// Shared constants, handshake structs and modulo helpers for the lagged Fibonacci generator.
package lfrg_pkg;

    // Table geometry
    localparam int LONG_LAG_DEF = 97;
    localparam int SHORT_LAG    = 33;
    localparam int WORD_W       = 24;
    localparam int SEED_W       = 32;
    localparam int LIMIT_W      = 32;
    localparam int SCALE_W      = 32;

    // Carry sequence
    localparam logic [WORD_W-1:0] CARRY_START = 24'd362436;
    localparam logic [WORD_W-1:0] CARRY_DEC   = 24'd7654321;
    localparam logic [WORD_W-1:0] CARRY_WRAP  = 24'(16777213 - 7654321);

    // Item kinds
    localparam logic MODE_RESEED = 1'b0;
    localparam logic MODE_DRAW   = 1'b1;

    // Seed split divisors
    localparam logic [14:0] DIV_IJ = 15'd31329;
    localparam logic [14:0] DIV_KL = 15'd30082;
    localparam logic [14:0] DIV_AB = 15'd177;
    localparam logic [14:0] DIV_CD = 15'd169;

    // Seed split reciprocals: floor(2^shift / divisor); the 32-bit seed needs the wider shift
    localparam int          SPLIT_SHIFT = 46;
    localparam int          SMALL_SHIFT = 32;
    localparam logic [31:0] RECIP_IJ    = 32'((64'd1 << SPLIT_SHIFT) / 64'(DIV_IJ));
    localparam logic [31:0] RECIP_KL    = 32'((64'd1 << SMALL_SHIFT) / 64'(DIV_KL));
    localparam logic [31:0] RECIP_AB    = 32'((64'd1 << SMALL_SHIFT) / 64'(DIV_AB));
    localparam logic [31:0] RECIP_CD    = 32'((64'd1 << SMALL_SHIFT) / 64'(DIV_CD));

    // Reciprocals for the small recurrences (floor(2^22 / m))
    localparam int          RECIP_SHIFT = 22;
    localparam logic [31:0] RECIP_179   = 32'd23431;
    localparam logic [31:0] RECIP_169   = 32'd24818;

    // Ring shift controls handed to every cell
    typedef struct packed {
        logic draw;   // take word from the higher neighbor
        logic fill;   // take word from the lower neighbor
    } t_shift;

    // Word stream from the seeder
    typedef struct packed {
        logic push;   // a finished table word is on the word bus
        logic done;   // this is the last word of the table
    } t_fill;

    // x mod 179 for x < 2^16: reciprocal estimate, then one correction
    function automatic logic [7:0] mod179(input logic [15:0] x);
        logic [31:0] prod;
        logic [8:0]  q;
        logic [16:0] r;
        prod = 32'(x) * RECIP_179;
        q    = prod[RECIP_SHIFT+8:RECIP_SHIFT];
        r    = 17'(x) - 17'(q) * 17'd179;
        if (r >= 17'd179) begin
            r = r - 17'd179;
        end
        return r[7:0];
    endfunction

    // x mod 169 for x < 2^16
    function automatic logic [7:0] mod169(input logic [15:0] x);
        logic [31:0] prod;
        logic [8:0]  q;
        logic [16:0] r;
        prod = 32'(x) * RECIP_169;
        q    = prod[RECIP_SHIFT+8:RECIP_SHIFT];
        r    = 17'(x) - 17'(q) * 17'd169;
        if (r >= 17'd169) begin
            r = r - 17'd169;
        end
        return r[7:0];
    endfunction

endpackage

>>> rtl/lfrg_cell.sv
// One 24-bit word of the lag table ring, shifting toward either neighbor.
module lfrg_cell
    import lfrg_pkg::*;
(
    input  logic              i_clk,
    input  t_shift            i_ctl,
    input  logic [WORD_W-1:0] i_from_hi,
    input  logic [WORD_W-1:0] i_from_lo,
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_word;

    // Draw rotates the ring down, fill pushes words up
    always_ff @(posedge i_clk) begin
        if (i_ctl.draw) begin
            r_word <= i_from_hi;
        end else if (i_ctl.fill) begin
            r_word <= i_from_lo;
        end
    end

    assign o_word = r_word;

endmodule

>>> rtl/lfrg_seed.sv
// Seed splitter (reciprocal divider) and bitwise table word generator.
module lfrg_seed
    import lfrg_pkg::*;
#(
    parameter int LONG_LAG = LONG_LAG_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SEED_W-1:0] i_seed,
    output t_fill             o_fill,
    output logic [WORD_W-1:0] o_word
);

    localparam int WCNT_W = $clog2(LONG_LAG);

    typedef enum logic [1:0] {SD_IDLE, SD_DIV, SD_BIT} t_state;
    typedef enum logic [1:0] {OP_SEED, OP_KL, OP_IJ, OP_CD} t_op;
    typedef enum logic [1:0] {DV_MUL, DV_EST, DV_FIX} t_dphase;
    typedef enum logic [2:0] {PH_MUL1, PH_MOD1, PH_MUL2, PH_MOD2, PH_BIT} t_phase;

    t_state            r_state;
    t_op               r_op;
    t_dphase           r_dphase;
    t_phase            r_phase;
    logic [SEED_W-1:0] r_dvd;
    logic [63:0]       r_dprod;
    logic [17:0]       r_q;
    logic [15:0]       r_rem;
    logic [14:0]       r_ij;
    logic [14:0]       r_kl;
    logic [7:0]        r_a;
    logic [7:0]        r_b;
    logic [7:0]        r_c;
    logic [7:0]        r_d;
    logic [7:0]        r_m;
    logic [15:0]       r_prod;
    logic [4:0]        r_bcnt;
    logic [WCNT_W-1:0] r_wcnt;
    logic [WORD_W-1:0] r_word;

    logic [14:0]       n_divisor;
    logic [31:0]       n_recip;
    logic [17:0]       n_qest;
    logic [32:0]       n_qd;
    logic [SEED_W-1:0] n_rdiff;
    logic              n_ge;
    logic [15:0]       n_diffr;
    logic [14:0]       n_rem;
    logic [17:0]       n_quo;
    logic [11:0]       n_bprod;
    logic              n_bit;

    // Reciprocal division: quotient estimate is exact or one low, then one correction
    always_comb begin
        case (r_op)
            OP_SEED: begin
                n_divisor = DIV_IJ;
                n_recip   = RECIP_IJ;
            end
            OP_KL: begin
                n_divisor = DIV_KL;
                n_recip   = RECIP_KL;
            end
            OP_IJ: begin
                n_divisor = DIV_AB;
                n_recip   = RECIP_AB;
            end
            OP_CD: begin
                n_divisor = DIV_CD;
                n_recip   = RECIP_CD;
            end
            default: begin
                n_divisor = DIV_IJ;
                n_recip   = RECIP_IJ;
            end
        endcase
        n_qest  = (r_op == OP_SEED) ? r_dprod[SPLIT_SHIFT+17:SPLIT_SHIFT]
                                    : r_dprod[SMALL_SHIFT+17:SMALL_SHIFT];
        n_qd    = 33'(n_qest) * 33'(n_divisor);
        n_rdiff = r_dvd - n_qd[SEED_W-1:0];
        n_ge    = (r_rem >= {1'b0, n_divisor});
        n_diffr = r_rem - {1'b0, n_divisor};
        n_rem   = n_ge ? n_diffr[14:0] : r_rem[14:0];
        n_quo   = n_ge ? r_q + 18'd1 : r_q;
    end

    // Output bit from the updated mod-169 and mod-179 terms; only bit 5 of d*m matters
    assign n_bprod = {6'd0, r_d[5:0]} * {6'd0, r_c[5:0]};
    assign n_bit   = n_bprod[5];

    assign o_word      = {r_word[WORD_W-2:0], n_bit};
    assign o_fill.push = (r_state == SD_BIT) && (r_phase == PH_BIT) &&
                         (r_bcnt == 5'(WORD_W - 1));
    assign o_fill.done = o_fill.push && (r_wcnt == WCNT_W'(LONG_LAG - 1));

    // Sequencer: four divisions (multiply, estimate, fix), then five phases per table bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SD_IDLE;
            r_op     <= OP_SEED;
            r_dphase <= DV_MUL;
            r_phase  <= PH_MUL1;
            r_bcnt   <= '0;
            r_wcnt   <= '0;
        end else begin
            case (r_state)
                SD_IDLE: begin
                    if (i_start) begin
                        r_dvd    <= i_seed;
                        r_dphase <= DV_MUL;
                        r_op     <= OP_SEED;
                        r_state  <= SD_DIV;
                    end
                end
                SD_DIV: begin
                    case (r_dphase)
                        DV_MUL: begin
                            r_dprod  <= 64'(r_dvd) * 64'(n_recip);
                            r_dphase <= DV_EST;
                        end
                        DV_EST: begin
                            r_q      <= n_qest;
                            r_rem    <= n_rdiff[15:0];
                            r_dphase <= DV_FIX;
                        end
                        default: begin
                            r_dphase <= DV_MUL;
                            case (r_op)
                                OP_SEED: begin
                                    r_ij  <= n_rem;
                                    r_dvd <= SEED_W'(n_quo);
                                    r_op  <= OP_KL;
                                end
                                OP_KL: begin
                                    r_kl  <= n_rem;
                                    r_dvd <= SEED_W'(r_ij);
                                    r_op  <= OP_IJ;
                                end
                                OP_IJ: begin
                                    r_a   <= n_quo[7:0] + 8'd2;
                                    r_b   <= n_rem[7:0] + 8'd2;
                                    r_dvd <= SEED_W'(r_kl);
                                    r_op  <= OP_CD;
                                end
                                default: begin
                                    r_c     <= n_quo[7:0] + 8'd1;
                                    r_d     <= n_rem[7:0];
                                    r_phase <= PH_MUL1;
                                    r_bcnt  <= '0;
                                    r_wcnt  <= '0;
                                    r_state <= SD_BIT;
                                end
                            endcase
                        end
                    endcase
                end
                SD_BIT: begin
                    case (r_phase)
                        PH_MUL1: begin
                            r_prod  <= 16'(r_a) * 16'(r_b);
                            r_phase <= PH_MOD1;
                        end
                        PH_MOD1: begin
                            r_m     <= mod179(r_prod);
                            r_d     <= mod169(16'(r_d) * 16'd53 + 16'd1);
                            r_phase <= PH_MUL2;
                        end
                        PH_MUL2: begin
                            r_prod  <= 16'(r_m) * 16'(r_c);
                            r_phase <= PH_MOD2;
                        end
                        PH_MOD2: begin
                            r_a     <= r_b;
                            r_b     <= r_c;
                            r_c     <= mod179(r_prod);
                            r_phase <= PH_BIT;
                        end
                        default: begin
                            r_word  <= o_word;
                            r_phase <= PH_MUL1;
                            if (o_fill.push) begin
                                r_bcnt <= '0;
                                r_wcnt <= r_wcnt + WCNT_W'(1);
                                if (o_fill.done) begin
                                    r_state <= SD_IDLE;
                                end
                            end else begin
                                r_bcnt <= r_bcnt + 5'd1;
                            end
                        end
                    endcase
                end
                default: r_state <= SD_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/lagged_fibonacci_random_generator_core.sv
// Top level of the lagged Fibonacci (RANMAR) generator: cell ring, carry and output stage.
//
// A draw beat rotates the 97-word cell ring and registers the 24-bit value, then puts the
// 24x32 scaling product into the output register once it is free. A reseed beat holds
// o_ready low through the seed split (four reciprocal divides) and the multiply, modulo
// and bit phases of each of the 2,328 table bits, a word being shifted into the ring every
// 24 bits. The next beat is taken while a finished result still waits on the output. The
// user must write the seed register only while the block is idle; the block does not
// enforce it. Its value is used when a reseed beat is accepted.
module lagged_fibonacci_random_generator_core
    import lfrg_pkg::*;
#(
    parameter int LONG_LAG = LONG_LAG_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SEED_W-1:0]  i_cfg_seed,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [WORD_W-1:0]  o_value,
    output logic [SCALE_W-1:0] o_scaled,
    output logic               o_not_seeded
);

    localparam int TAP = LONG_LAG - SHORT_LAG;

    typedef enum logic [1:0] {S_IDLE, S_FILL, S_EMIT} t_state;

    t_state             r_state;
    logic [SEED_W-1:0]  r_seed;
    logic [WORD_W-1:0]  r_carry;
    logic               r_seeded;
    logic [WORD_W-1:0]  r_pend_val;
    logic [LIMIT_W-1:0] r_pend_lim;
    logic               r_pend_ns;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_value;
    logic [SCALE_W-1:0] r_out_scaled;
    logic               r_out_ns;

    logic               w_accept;
    logic               w_draw;
    logic               w_load;
    t_shift             w_shift;
    t_fill              w_fill;
    logic [WORD_W-1:0]  w_fill_word;
    logic [WORD_W-1:0]  w_cell [LONG_LAG];
    logic [WORD_W-1:0]  n_diff;
    logic [WORD_W-1:0]  n_carry;
    logic [WORD_W-1:0]  n_value;
    logic [WORD_W+LIMIT_W-1:0] n_prod;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_draw      = w_accept && (i_mode == MODE_DRAW) && r_seeded;
    assign w_load      = (r_state == S_EMIT) && (!r_out_valid || i_ready);

    assign w_shift.draw = w_draw;
    assign w_shift.fill = w_fill.push;

    // Seed split and table word stream
    lfrg_seed #(
        .LONG_LAG(LONG_LAG)
    ) u_seed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && (i_mode == MODE_RESEED)),
        .i_seed  (r_seed),
        .o_fill  (w_fill),
        .o_word  (w_fill_word)
    );

    // Cell ring: cell 0 is the upper lag word, cell TAP the lower lag word
    for (genvar k = 0; k < LONG_LAG; k++) begin : g_cell
        logic [WORD_W-1:0] w_hi;
        logic [WORD_W-1:0] w_lo;
        if (k == LONG_LAG - 1) begin : g_top
            assign w_hi = n_diff;
        end else begin : g_mid_hi
            assign w_hi = w_cell[k+1];
        end
        if (k == 0) begin : g_bot
            assign w_lo = w_fill_word;
        end else begin : g_mid_lo
            assign w_lo = w_cell[k-1];
        end
        lfrg_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_shift),
            .i_from_hi (w_hi),
            .i_from_lo (w_lo),
            .o_word    (w_cell[k])
        );
    end

    // Lag difference, carry step and value
    always_comb begin
        n_diff = w_cell[0] - w_cell[TAP];
        if (r_carry < CARRY_DEC) begin
            n_carry = r_carry + CARRY_WRAP;
        end else begin
            n_carry = r_carry - CARRY_DEC;
        end
        n_value = n_diff - n_carry;
    end

    assign n_prod = (WORD_W+LIMIT_W)'(r_pend_val) * (WORD_W+LIMIT_W)'(r_pend_lim);

    // Seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed <= i_cfg_seed;
        end
    end

    // Control state machine and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_carry     <= CARRY_START;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pend_val <= '0;
                        r_pend_lim <= '0;
                        r_pend_ns  <= 1'b0;
                        if (i_mode == MODE_RESEED) begin
                            r_state <= S_FILL;
                        end else begin
                            r_state <= S_EMIT;
                            if (r_seeded) begin
                                r_carry    <= n_carry;
                                r_pend_val <= n_value;
                                r_pend_lim <= i_limit;
                            end else begin
                                r_pend_ns <= 1'b1;
                            end
                        end
                    end
                end
                S_FILL: begin
                    if (w_fill.done) begin
                        r_carry  <= CARRY_START;
                        r_seeded <= 1'b1;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // Output beat
            if (w_load) begin
                r_out_valid  <= 1'b1;
                r_out_value  <= r_pend_val;
                r_out_scaled <= n_prod[WORD_W+LIMIT_W-1:WORD_W];
                r_out_ns     <= r_pend_ns;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_value      = r_out_value;
    assign o_scaled     = r_out_scaled;
    assign o_not_seeded = r_out_ns;

endmodule

>>> rtl/lfrg_chk.sv
// Port-level checker for the lagged Fibonacci generator, bound to the top level.
module lfrg_chk
    import lfrg_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [WORD_W-1:0]  o_value,
    input logic [SCALE_W-1:0] o_scaled,
    input logic               o_not_seeded
);

    // A held output beat does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_scaled) &&
                                $stable(o_not_seeded))
        else $error("output beat changed while stalled");

    // An unseeded draw reports zeros
    a_ns_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_not_seeded |-> o_value == '0 && o_scaled == '0)
        else $error("unseeded result carries data");

    // Zero fraction scales to zero
    a_scale_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_value == '0 |-> o_scaled == '0)
        else $error("scaled nonzero for zero value");

    // One item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second beat taken while busy");

endmodule

bind lagged_fibonacci_random_generator_core lfrg_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_value      (o_value),
    .o_scaled     (o_scaled),
    .o_not_seeded (o_not_seeded)
);

>>> tb/lagged_fibonacci_random_generator_core_tb.sv
// Self-checking testbench for the lagged Fibonacci generator core: directed and random beats.
`timescale 1ns / 100ps

module lagged_fibonacci_random_generator_core_tb;
    import lfrg_pkg::*;

    // Seed whose split lands on the top of both ranges (ij = 31328, kl = 30081)
    localparam logic [SEED_W-1:0] SEED_SPLIT_MAX = 32'd942438977;
    localparam int unsigned MOD_ABC   = 179;
    localparam int unsigned MUL_D     = 53;
    localparam int          TAIL_WAIT = 20;

    typedef struct packed {
        logic [WORD_W-1:0]  value;
        logic [SCALE_W-1:0] scaled;
        logic               not_seeded;
    } t_draw_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [SEED_W-1:0]  i_cfg_seed;
    logic               i_valid;
    logic               o_ready;
    logic               i_mode;
    logic [LIMIT_W-1:0] i_limit;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [WORD_W-1:0]  o_value;
    logic [SCALE_W-1:0] o_scaled;
    logic               o_not_seeded;

    // Generator shadow state
    logic [WORD_W-1:0] lag_words [0:LONG_LAG_DEF-1];
    logic [WORD_W-1:0] carry_acc;
    logic [6:0]        upper_ptr;
    logic [6:0]        lower_ptr;
    logic              is_seeded;
    logic [SEED_W-1:0] seed_shadow;

    t_draw_result results_due [$];
    int err_count     = 0;
    int send_idle_pct = 13;
    int recv_idle_pct = 79;

    lagged_fibonacci_random_generator_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_seed   (i_cfg_seed),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_limit      (i_limit),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value      (o_value),
        .o_scaled     (o_scaled),
        .o_not_seeded (o_not_seeded)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side back-pressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Scoreboard: check result beats, track the seed register, predict accepted beats
    always @(posedge i_clk) begin : scoreboard
        t_draw_result      want;
        logic [WORD_W-1:0] diff;
        logic [WORD_W-1:0] frac;
        logic [WORD_W-1:0] word;
        logic [55:0]       prod;
        int unsigned       ij, kl, a, b, c, d, m;
        int                w, k;
        if (!i_rst_n) begin
            carry_acc   = CARRY_START;
            upper_ptr   = 7'(LONG_LAG_DEF);
            lower_ptr   = 7'(SHORT_LAG);
            is_seeded   = 1'b0;
            seed_shadow = '0;
            results_due.delete();
        end else begin
            // result beat against the oldest expectation
            if (o_valid && i_ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result beat: value %0d scaled %0d not_seeded %0b",
                           o_value, o_scaled, o_not_seeded);
                    err_count++;
                end else begin
                    want = results_due.pop_front();
                    if (o_value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, o_value);
                        err_count++;
                    end
                    if (o_scaled !== want.scaled) begin
                        $error("scaled: expected %0d, got %0d", want.scaled, o_scaled);
                        err_count++;
                    end
                    if (o_not_seeded !== want.not_seeded) begin
                        $error("not_seeded: expected %0b, got %0b",
                               want.not_seeded, o_not_seeded);
                        err_count++;
                    end
                end
            end

            if (i_cfg_valid && o_cfg_ready) begin
                seed_shadow = i_cfg_seed;
            end

            // accepted input beat
            if (i_valid && o_ready) begin
                want = '0;
                if (i_mode == MODE_RESEED) begin
                    // split the seed and run the two small recurrences, MSB first
                    ij = seed_shadow % DIV_IJ;
                    kl = (seed_shadow / DIV_IJ) % DIV_KL;
                    a  = (ij / DIV_AB) % DIV_AB + 2;
                    b  = ij % DIV_AB + 2;
                    c  = (kl / DIV_CD) % 178 + 1;
                    d  = kl % DIV_CD;
                    for (w = 0; w < LONG_LAG_DEF; w++) begin
                        word = '0;
                        for (k = 0; k < WORD_W; k++) begin
                            m    = (((a * b) % MOD_ABC) * c) % MOD_ABC;
                            a    = b;
                            b    = c;
                            c    = m;
                            d    = (MUL_D * d + 1) % DIV_CD;
                            word = {word[WORD_W-2:0], (((d * m) & 63) >= 32)};
                        end
                        lag_words[w] = word;
                    end
                    carry_acc = CARRY_START;
                    upper_ptr = 7'(LONG_LAG_DEF);
                    lower_ptr = 7'(SHORT_LAG);
                    is_seeded = 1'b1;
                end else if (!is_seeded) begin
                    want.not_seeded = 1'b1;
                end else begin
                    diff = lag_words[upper_ptr-1] - lag_words[lower_ptr-1];
                    lag_words[upper_ptr-1] = diff;
                    upper_ptr = (upper_ptr <= 1) ? 7'(LONG_LAG_DEF) : upper_ptr - 7'd1;
                    lower_ptr = (lower_ptr <= 1) ? 7'(LONG_LAG_DEF) : lower_ptr - 7'd1;
                    if (carry_acc < CARRY_DEC) begin
                        carry_acc = carry_acc + CARRY_WRAP;
                    end else begin
                        carry_acc = carry_acc - CARRY_DEC;
                    end
                    frac        = diff - carry_acc;
                    prod        = 56'(frac) * 56'(i_limit);
                    want.value  = frac;
                    want.scaled = prod[55:24];
                end
                results_due.push_back(want);
            end
        end
    end

    // One input beat; leaves valid high at the falling edge after acceptance
    task automatic send_item(input logic mode, input logic [LIMIT_W-1:0] lim);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_limit <= lim;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Stop sending and hold off until every result has come back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (results_due.size() != 0);
    endtask

    // Seed register write; only called with the block idle
    task automatic write_seed(input logic [SEED_W-1:0] seed);
        i_cfg_valid <= 1'b1;
        i_cfg_seed  <= seed;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Draws before any reseed must flag not_seeded and leave the state alone
    task automatic test_unseeded_draw();
        send_item(MODE_DRAW, '0);
        send_item(MODE_DRAW, 32'd1);
        send_item(MODE_DRAW, '1);
        send_item(MODE_DRAW, 32'h8000_0000);
    endtask

    // Seed extremes with limit extremes, including a zero limit
    task automatic test_seed_extremes();
        logic [SEED_W-1:0]  seeds [3];
        logic [LIMIT_W-1:0] lims [4];
        int s, n;
        seeds = '{32'd0, SEED_SPLIT_MAX, 32'hFFFF_FFFF};
        lims  = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000};
        for (s = 0; s < 3; s++) begin
            wait_for_results();
            write_seed(seeds[s]);
            send_item(MODE_RESEED, $urandom);
            for (n = 0; n < 4; n++) begin
                send_item(MODE_DRAW, lims[n]);
            end
        end
    endtask

    // Reseed right behind draws and right behind another reseed
    task automatic test_back_to_back_reseed();
        send_item(MODE_RESEED, $urandom);
        send_item(MODE_RESEED, $urandom);
        send_item(MODE_DRAW, $urandom);
        send_item(MODE_DRAW, $urandom);
    endtask

    // Segments of: seed write, reseed, a run of draws with rare reseeds mixed in
    task automatic test_random_traffic(input int n_items, input int send_pct,
                                       input int recv_pct);
        logic [SEED_W-1:0]  seed;
        logic [LIMIT_W-1:0] lim;
        int sent, seg_len, n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            wait_for_results();
            case ($urandom_range(7))
                0:       seed = '0;
                1:       seed = '1;
                2:       seed = SEED_SPLIT_MAX;
                default: seed = $urandom;
            endcase
            write_seed(seed);
            send_item(MODE_RESEED, $urandom);
            seg_len = $urandom_range(40, 160);
            if (seg_len > n_items - sent - 1) begin
                seg_len = n_items - sent - 1;
            end
            for (n = 0; n < seg_len; n++) begin
                case ($urandom_range(7))
                    0:       lim = '0;
                    1:       lim = '1;
                    2:       lim = $urandom_range(15);
                    default: lim = $urandom;
                endcase
                send_item(($urandom_range(127) == 0) ? MODE_RESEED : MODE_DRAW, lim);
            end
            sent += seg_len + 1;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_seed  = '0;
        i_valid     = 1'b0;
        i_mode      = MODE_DRAW;
        i_limit     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_unseeded_draw();
        test_seed_extremes();
        test_back_to_back_reseed();
        test_random_traffic(310, 13, 79);
        test_random_traffic(310, 79, 13);
        test_random_traffic(310, 0, 0);

        wait_for_results();
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: several times the slowest expected run
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
rtl/lfrg_pkg.sv
rtl/lfrg_cell.sv
rtl/lfrg_seed.sv
rtl/lagged_fibonacci_random_generator_core.sv
rtl/lfrg_chk.sv
tb/lagged_fibonacci_random_generator_core_tb.sv
